// File: src/bnwms_pkg.sv
`timescale 1ns / 1ps
package bnwms_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int BEST_W      = 27;
	localparam int CFG_W       = 11;
	localparam int DEF_MAX_LEN = 1024;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [BEST_W-1:0]   best_t;
	typedef logic [CFG_W-1:0]           cfg_t;

	localparam best_t BEST_START = best_t'(-9999);
	localparam best_t BEST_MAX   = {1'b0, {(BEST_W-1){1'b1}}};
	localparam best_t BEST_MIN   = {1'b1, {(BEST_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_POP
	} state_t;

endpackage

// File: src/bnwms_if.sv
`timescale 1ns / 1ps
interface bnwms_in_if;
	logic                valid;
	logic                ready;
	bnwms_pkg::sample_t  sample;
	logic                last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface bnwms_out_if;
	logic              valid;
	logic              ready;
	bnwms_pkg::best_t  best_sum;
	logic              last_res;
	logic              overflow;

	modport source (output valid, output best_sum, output last_res, output overflow,
		input ready);
	modport sink   (input valid, input best_sum, input last_res, input overflow,
		output ready);
endinterface

interface bnwms_cfg_if;
	logic             valid;
	logic             ready;
	bnwms_pkg::cfg_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/bounded_negative_window_max_sum_top.sv
`timescale 1ns / 1ps
// channel   dir   payload                          request when
// samples   in    sample[15:0] signed, last        valid && ready
// results   out   best_sum[26:0] signed, last_res, valid && ready
//                 overflow
// cfg       in    data[10:0] = max_negatives       valid && ready (ready always high)
//
// an item is accepted, then checked and its result loaded; each old sample dropped
// from the window adds a store read and a step to apply it
// the window store is a single-port-read ring memory; its read latency sets the drop cost
// reset clears pointers, counts, sums and best; the store needs no clearing pass
// a waiting result does not block the next request; the check stage stalls only
// when the result register is still full
module bounded_negative_window_max_sum_top #(
	parameter int MAX_LEN = bnwms_pkg::DEF_MAX_LEN
) (
	input  logic         clk,
	input  logic         arst_n,
	bnwms_in_if.sink     samples,
	bnwms_out_if.source  results,
	bnwms_cfg_if.sink    cfg
);
	import bnwms_pkg::*;

	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int SUM_W = (SAMPLE_W + CNT_W > BEST_W) ? SAMPLE_W + CNT_W : BEST_W + 1;
	localparam int NEG_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	state_t state_q, state_d;

	cfg_t                    max_neg_q;
	logic [CNT_W-1:0]        head_q, tail_q, items_q, neg_q;
	logic signed [SUM_W-1:0] sum_q;
	best_t                   best_q;
	logic                    ovf_q, last_q;

	logic                    res_valid_q;
	best_t                   res_best_q;
	logic                    res_last_q, res_ovf_q;

	sample_t                 store_mem [MAX_LEN];
	sample_t                 rd_data_s1;

	logic                    in_acc, full, wr_en, rd_en, load, pop_need, out_free;
	best_t                   win_sat, best_new;

	assign cfg.ready     = 1'b1;
	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign full          = (items_q >= CNT_W'(MAX_LEN));
	assign wr_en         = in_acc && !full;
	assign out_free      = !res_valid_q || results.ready;
	assign pop_need      = (NEG_W'(neg_q) > NEG_W'(max_neg_q)) && (head_q < tail_q);

	// saturate window sum and pick the new best
	always_comb begin
		if (sum_q > SUM_W'(BEST_MAX)) begin
			win_sat = BEST_MAX;
		end else if (sum_q < SUM_W'(BEST_MIN)) begin
			win_sat = BEST_MIN;
		end else begin
			win_sat = sum_q[BEST_W-1:0];
		end
		best_new = (!ovf_q && (win_sat > best_q)) ? win_sat : best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!ovf_q && pop_need) begin
					rd_en   = 1'b1;
					state_d = ST_POP;
				end else if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				state_d = ST_CHECK;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ring store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[tail_q[IDX_W-1:0]] <= samples.sample;
		end
		if (rd_en) begin
			rd_data_s1 <= store_mem[head_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_neg_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			items_q     <= '0;
			neg_q       <= '0;
			sum_q       <= '0;
			best_q      <= BEST_START;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				max_neg_q <= cfg.data;
			end
			if (wr_en) begin
				tail_q  <= tail_q + 1'b1;
				items_q <= items_q + 1'b1;
				neg_q   <= neg_q + CNT_W'(samples.sample[SAMPLE_W-1]);
				sum_q   <= sum_q + SUM_W'(samples.sample);
			end
			if (state_q == ST_POP) begin
				head_q <= head_q + 1'b1;
				neg_q  <= neg_q - CNT_W'(rd_data_s1[SAMPLE_W-1]);
				sum_q  <= sum_q - SUM_W'(rd_data_s1);
			end
			if (load) begin
				if (last_q) begin
					head_q  <= '0;
					tail_q  <= '0;
					items_q <= '0;
					neg_q   <= '0;
					sum_q   <= '0;
					best_q  <= BEST_START;
				end else begin
					best_q <= best_new;
				end
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ovf_q  <= full;
			last_q <= samples.last;
		end
		if (load) begin
			res_best_q <= best_new;
			res_last_q <= last_q;
			res_ovf_q  <= ovf_q;
		end
	end

	assign results.valid    = res_valid_q;
	assign results.best_sum = res_best_q;
	assign results.last_res = res_last_q;
	assign results.overflow = res_ovf_q;

	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("window head passed tail");

	a_tail_le_items: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= items_q)
		else $error("tail ahead of item count");

	a_pop_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> $past(state_q == ST_CHECK))
		else $error("store read without check");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_CHECK))
		else $error("accepted request not processed");

endmodule

// File: sim/tb_bounded_negative_window_max_sum_top.sv
`timescale 1ns / 1ps
module tb_bounded_negative_window_max_sum_top;
	import bnwms_pkg::*;

	localparam int DEPTH       = DEF_MAX_LEN;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 200;

	typedef struct {
		best_t best;
		logic  last;
		logic  ovf;
	} window_result_t;

	logic clk = 1'b0;
	logic arst_n;

	bnwms_in_if  samples_if();
	bnwms_out_if results_if();
	bnwms_cfg_if cfg_if();

	bounded_negative_window_max_sum_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if.sink),
		.results (results_if.source),
		.cfg     (cfg_if.sink)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	sample_t        win_mem [DEPTH];
	int             head_ptr;
	int             tail_ptr;
	int             seen_cnt;
	int             neg_cnt;
	longint         run_sum;
	longint         peak_sum;
	int             neg_limit;
	window_result_t pending_results[$];

	int  mismatches;
	int  sample_count;
	int  cycles;
	int  ready_hold;
	bit  steady_feed;

	function automatic void clear_window();
		head_ptr = 0;
		tail_ptr = 0;
		seen_cnt = 0;
		neg_cnt  = 0;
		run_sum  = 0;
		peak_sum = longint'(BEST_START);
	endfunction

	function automatic longint clamp27(longint x);
		if (x > longint'(BEST_MAX))
			return longint'(BEST_MAX);
		if (x < longint'(BEST_MIN))
			return longint'(BEST_MIN);
		return x;
	endfunction

	function automatic window_result_t advance_window(sample_t s, logic l);
		window_result_t r;
		longint w;
		r.ovf = 1'b0;
		if (seen_cnt >= DEPTH) begin
			r.ovf = 1'b1;
		end else begin
			seen_cnt++;
			if (tail_ptr < DEPTH) begin
				win_mem[tail_ptr] = s;
				tail_ptr++;
			end
			if (s < 0)
				neg_cnt++;
			run_sum += s;
			while (neg_cnt > neg_limit && head_ptr < tail_ptr) begin
				if (win_mem[head_ptr] < 0)
					neg_cnt--;
				run_sum -= win_mem[head_ptr];
				head_ptr++;
			end
			w = clamp27(run_sum);
			if (w > peak_sum)
				peak_sum = w;
		end
		r.best = best_t'(clamp27(peak_sum));
		r.last = l;
		if (l)
			clear_window();
		return r;
	endfunction

	task automatic report_mismatch(string what, logic signed [63:0] want,
		logic signed [63:0] got);
		$display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
		mismatches++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sample_t random_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3, 4: return sample_t'(int'($urandom_range(0, 200)) - 100);
			5, 6: return sample_t'($urandom);
			7: return sample_t'(-int'($urandom_range(1, 50)));
			default: return sample_t'($urandom_range(0, 2000));
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic push_sample(sample_t s, logic l);
		int gap;
		gap = steady_feed ? 0 : pick_gap();
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid  <= 1'b1;
		samples_if.sample <= s;
		samples_if.last   <= l;
		do @(posedge clk); while (!samples_if.ready);
		pending_results.push_back(advance_window(s, l));
		sample_count++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		samples_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_limit(cfg_t v);
		drain_results();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		do @(posedge clk); while (!cfg_if.ready);
		neg_limit = int'(v);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic test_reset_limit_extremes();
		// limit 0 after reset: every negative empties the window
		push_sample(16'sh7FFF, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh0000, 1'b0);
		push_sample(-16'sd1, 1'b0);
		push_sample(16'sd1, 1'b1);
		push_sample(16'sh8000, 1'b1);
	endtask

	task automatic test_limit_values();
		write_limit(cfg_t'(1024));
		push_sample(16'sh8000, 1'b1);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh7FFF, 1'b0);
		push_sample(-16'sd1, 1'b0);
		push_sample(16'sd100, 1'b1);
		write_limit(cfg_t'(2047));
		push_sample(-16'sd5, 1'b0);
		push_sample(-16'sd5, 1'b0);
		push_sample(16'sd3, 1'b1);
		write_limit(cfg_t'(1));
		push_sample(16'sd5, 1'b0);
		push_sample(-16'sd10, 1'b0);
		push_sample(16'sd20, 1'b0);
		push_sample(-16'sd30, 1'b0);
		push_sample(16'sd40, 1'b1);
	endtask

	task automatic test_store_overrun();
		write_limit(cfg_t'(1024));
		for (int i = 0; i < DEPTH; i++)
			push_sample((i % 50 == 7) ? 16'sh8000 : 16'sh7FFF, 1'b0);
		push_sample(16'sh7FFF, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sd9, 1'b1);
		// state must be clear again
		push_sample(-16'sd3, 1'b0);
		push_sample(16'sd4, 1'b1);
	endtask

	task automatic test_random_sequences();
		int target;
		int nseq;
		int len;
		int r;
		cfg_t v;
		target = sample_count + RANDOM_ITEMS;
		while (sample_count < target) begin
			case ($urandom_range(0, 7))
				0: v = '0;
				1: v = cfg_t'(1);
				2: v = cfg_t'(2);
				3: v = cfg_t'($urandom_range(3, 8));
				4: v = cfg_t'($urandom_range(0, 2047));
				5: v = cfg_t'(1024);
				6: v = cfg_t'(2047);
				default: v = cfg_t'($urandom_range(0, 15));
			endcase
			write_limit(v);
			steady_feed = ($urandom_range(0, 3) == 0);
			nseq = $urandom_range(2, 6);
			for (int q = 0; q < nseq; q++) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					len = $urandom_range(1, 24);
				else if (r < 95)
					len = $urandom_range(25, 120);
				else
					len = $urandom_range(1, 3);
				for (int k = 0; k < len; k++)
					push_sample(random_sample(),
						(k == len - 1) && !(q == nseq - 1 && $urandom_range(0, 7) == 0));
			end
			steady_feed = 1'b0;
		end
	endtask

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if ($urandom_range(0, 3) == 0) begin
			results_if.ready <= 1'b0;
			ready_hold = 1 + pick_gap();
		end else begin
			results_if.ready <= 1'b1;
			ready_hold = $urandom_range(0, 20);
		end
	end

	always @(posedge clk) begin : check_results
		window_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", 0, results_if.best_sum);
			end else begin
				want = pending_results.pop_front();
				if (results_if.best_sum !== want.best)
					report_mismatch("best_sum", want.best, results_if.best_sum);
				if (results_if.last_res !== want.last)
					report_mismatch("last_res", want.last, results_if.last_res);
				if (results_if.overflow !== want.ovf)
					report_mismatch("overflow", want.ovf, results_if.overflow);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		samples_if.valid  = 1'b0;
		samples_if.sample = '0;
		samples_if.last   = 1'b0;
		results_if.ready  = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.data       = '0;
		mismatches        = 0;
		sample_count      = 0;
		cycles            = 0;
		ready_hold        = 0;
		steady_feed       = 1'b0;
		neg_limit         = 0;
		clear_window();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_limit_extremes();
		test_limit_values();
		test_store_overrun();
		test_random_sequences();

		drain_results();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
